[hdl/gcsp_pkg.sv]
// Package for the Gray-code stripe pixel generator.
// Holds image limits, field widths, register indexes and the pipeline types.
// Used by every module under hdl.
`default_nettype none

package gcsp_pkg;

    localparam int FRAME_ROWS     = 1024;
    localparam int FRAME_COLS     = 1024;
    localparam int PATTERN_BITS_D = 10;

    localparam int IDX_W  = 5;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 11;
    localparam int PLANE_W = 4;
    localparam int PIX_W  = 8;
    localparam int CFG_W  = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_TOP    = 3'd0,
        REG_WINDOW_LEFT   = 3'd1,
        REG_WINDOW_HEIGHT = 3'd2,
        REG_WINDOW_WIDTH  = 3'd3,
        REG_MARK_TOP      = 3'd4,
        REG_MARK_LEFT     = 3'd5,
        REG_MARK_HEIGHT   = 3'd6,
        REG_MARK_WIDTH    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [POS_W-1:0] window_top;
        logic [POS_W-1:0] window_left;
        logic [LEN_W-1:0] window_height;
        logic [LEN_W-1:0] window_width;
        logic [POS_W-1:0] mark_top;
        logic [POS_W-1:0] mark_left;
        logic [LEN_W-1:0] mark_height;
        logic [LEN_W-1:0] mark_width;
    } t_cfg;

    // One pixel in flight. lit_ok is clear when the pixel is black for
    // reasons other than the stripe (outside image or window, bad index, mark).
    typedef struct packed {
        logic               lit_ok;
        logic               invert;
        logic [PLANE_W-1:0] plane;
        logic [LEN_W-1:0]   rem;
        logic               last_bit;
        logic               stripe;
    } t_item;

endpackage

`default_nettype wire

[hdl/gcsp_front.sv]
// First pipeline stage: window, image and mark decode, relative row.
// Depends on gcsp_pkg for the configuration and item types.
`default_nettype none

module gcsp_front #(
    parameter int PATTERN_BITS = gcsp_pkg::PATTERN_BITS_D
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gcsp_pkg::t_cfg               i_cfg,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [gcsp_pkg::IDX_W-1:0]   i_image_index,
    input  wire logic [gcsp_pkg::POS_W-1:0]   i_pixel_row,
    input  wire logic [gcsp_pkg::POS_W-1:0]   i_pixel_col,
    input  wire logic                         i_mark_enable,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output gcsp_pkg::t_item                   o_item
);

    localparam int SPAN_W = gcsp_pkg::LEN_W + 1;
    localparam int IMG_W  = 13;

    logic            r_valid;
    gcsp_pkg::t_item r_item;
    gcsp_pkg::t_item n_item;

    logic in_image, idx_ok, win_row, win_col, mark_row, mark_col;

    always_comb begin
        in_image = ({3'b000, i_pixel_row} < IMG_W'(gcsp_pkg::FRAME_ROWS)) &&
                   ({3'b000, i_pixel_col} < IMG_W'(gcsp_pkg::FRAME_COLS));
        idx_ok   = {1'b0, i_image_index} < 6'(2 * PATTERN_BITS);
        win_row  = (i_pixel_row >= i_cfg.window_top) &&
                   ({2'b00, i_pixel_row} <
                    {2'b00, i_cfg.window_top} + {1'b0, i_cfg.window_height});
        win_col  = (i_pixel_col >= i_cfg.window_left) &&
                   ({2'b00, i_pixel_col} <
                    {2'b00, i_cfg.window_left} + {1'b0, i_cfg.window_width});
        mark_row = (i_pixel_row >= i_cfg.mark_top) &&
                   ({2'b00, i_pixel_row} <
                    SPAN_W'({2'b00, i_cfg.mark_top} + {1'b0, i_cfg.mark_height}));
        mark_col = (i_pixel_col >= i_cfg.mark_left) &&
                   ({2'b00, i_pixel_col} <
                    SPAN_W'({2'b00, i_cfg.mark_left} + {1'b0, i_cfg.mark_width}));

        n_item.lit_ok   = in_image && idx_ok && win_row && win_col &&
                          !(i_mark_enable && mark_row && mark_col);
        n_item.invert   = i_image_index[0];
        n_item.plane    = i_image_index[gcsp_pkg::IDX_W-1:1];
        // Inside the window the relative row is below the window height,
        // so the long division below starts with a proper fraction.
        n_item.rem      = {1'b0, i_pixel_row - i_cfg.window_top};
        n_item.last_bit = 1'b0;
        n_item.stripe   = 1'b0;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[hdl/gcsp_div_stage.sv]
// One step of the pipelined long division of relative row by window height.
// Depends on gcsp_pkg for the item type and field widths.
`default_nettype none

module gcsp_div_stage #(
    parameter int STEP = 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [gcsp_pkg::LEN_W-1:0]   i_height,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire gcsp_pkg::t_item              i_item,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output gcsp_pkg::t_item                   o_item
);

    localparam int WIDE_W = gcsp_pkg::LEN_W + 1;
    localparam logic [gcsp_pkg::PLANE_W-1:0] PLANE_SEL = gcsp_pkg::PLANE_W'(STEP - 1);

    logic                         r_valid;
    gcsp_pkg::t_item              r_item;
    gcsp_pkg::t_item              n_item;
    logic [WIDE_W-1:0]            twice;
    logic [gcsp_pkg::LEN_W-1:0]   diff;
    logic                         frac_bit;

    // This stage yields fractional bit STEP of row/height. Rounding to
    // nearest at plane b flips the parity of bit b by bit b+1, so the
    // stripe value is the XOR of the two.
    always_comb begin
        twice    = {i_item.rem, 1'b0};
        // The difference is below the height whenever it is taken.
        diff     = twice[gcsp_pkg::LEN_W-1:0] - i_height;
        frac_bit = twice >= {1'b0, i_height};
        n_item   = i_item;
        n_item.rem      = frac_bit ? diff : twice[gcsp_pkg::LEN_W-1:0];
        n_item.last_bit = frac_bit;
        if (i_item.plane == PLANE_SEL) begin
            n_item.stripe = i_item.last_bit ^ frac_bit;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[hdl/gcsp_out.sv]
// Last pipeline stage: turns the stripe bit into a grey level and holds it.
// Depends on gcsp_pkg for the item type and pixel constants.
`default_nettype none

module gcsp_out (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire gcsp_pkg::t_item              i_item,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [gcsp_pkg::PIX_W-1:0]        o_pixel_value
);

    logic                         r_valid;
    logic [gcsp_pkg::PIX_W-1:0]   r_pixel;
    logic [gcsp_pkg::PIX_W-1:0]   n_pixel;

    always_comb begin
        if (i_item.lit_ok && (i_item.stripe ^ i_item.invert)) begin
            n_pixel = gcsp_pkg::PIX_ON;
        end else begin
            n_pixel = gcsp_pkg::PIX_OFF;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel_value = r_pixel;

endmodule

`default_nettype wire

[hdl/gray_code_stripe_pixel_generator.sv]
// Gray-code stripe pixel generator, top level with configuration registers.
// Depends on gcsp_pkg, gcsp_front, gcsp_div_stage and gcsp_out.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one pixel request: image index,
//   row, column and mark enable. Output channel (o_valid / i_ready) returns
//   the 8-bit grey level of that pixel, 0 or 255, in request order.
//   The pipeline is one decode stage, one long-division step per bit plane,
//   and the output register. Throughput is one pixel per cycle while i_ready
//   stays high; the number of division steps sets the depth, not the rate.
//   Each stage holds its own valid bit and takes a new item whenever it is
//   empty or its item moves on, so a stalled receiver first fills the empty
//   stages and then holds o_ready low; nothing is dropped or repeated.
//   Configuration writes (i_cfg_wr_en, i_cfg_index, i_cfg_data) take effect
//   at the next edge and must be made while no pixel is in flight.
//   Reset empties the pipeline and loads the register defaults: a full
//   1024 x 1024 window at the origin and an empty mark.
`default_nettype none

module gray_code_stripe_pixel_generator #(
    parameter int PATTERN_BITS = gcsp_pkg::PATTERN_BITS_D
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [gcsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [gcsp_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [gcsp_pkg::IDX_W-1:0]     i_image_index,
    input  wire logic [gcsp_pkg::POS_W-1:0]     i_pixel_row,
    input  wire logic [gcsp_pkg::POS_W-1:0]     i_pixel_col,
    input  wire logic                           i_mark_enable,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [gcsp_pkg::PIX_W-1:0]          o_pixel_value
);

    gcsp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_top    <= '0;
            r_cfg.window_left   <= '0;
            r_cfg.window_height <= 11'd1024;
            r_cfg.window_width  <= 11'd1024;
            r_cfg.mark_top      <= '0;
            r_cfg.mark_left     <= '0;
            r_cfg.mark_height   <= '0;
            r_cfg.mark_width    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (gcsp_pkg::t_reg_idx'(i_cfg_index))
                gcsp_pkg::REG_WINDOW_TOP:    r_cfg.window_top    <= i_cfg_data[9:0];
                gcsp_pkg::REG_WINDOW_LEFT:   r_cfg.window_left   <= i_cfg_data[9:0];
                gcsp_pkg::REG_WINDOW_HEIGHT: r_cfg.window_height <= i_cfg_data;
                gcsp_pkg::REG_WINDOW_WIDTH:  r_cfg.window_width  <= i_cfg_data;
                gcsp_pkg::REG_MARK_TOP:      r_cfg.mark_top      <= i_cfg_data[9:0];
                gcsp_pkg::REG_MARK_LEFT:     r_cfg.mark_left     <= i_cfg_data[9:0];
                gcsp_pkg::REG_MARK_HEIGHT:   r_cfg.mark_height   <= i_cfg_data;
                gcsp_pkg::REG_MARK_WIDTH:    r_cfg.mark_width    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage k of the chain hands over on s_valid[k] / s_ready[k].
    logic [PATTERN_BITS:0] s_valid;
    logic [PATTERN_BITS:0] s_ready;
    gcsp_pkg::t_item       s_item [PATTERN_BITS+1];

    gcsp_front #(
        .PATTERN_BITS (PATTERN_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_image_index (i_image_index),
        .i_pixel_row   (i_pixel_row),
        .i_pixel_col   (i_pixel_col),
        .i_mark_enable (i_mark_enable),
        .o_valid       (s_valid[0]),
        .i_ready       (s_ready[0]),
        .o_item        (s_item[0])
    );

    for (genvar k = 1; k <= PATTERN_BITS; k++) begin : g_div
        gcsp_div_stage #(
            .STEP (k)
        ) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_height (r_cfg.window_height),
            .i_valid  (s_valid[k-1]),
            .o_ready  (s_ready[k-1]),
            .i_item   (s_item[k-1]),
            .o_valid  (s_valid[k]),
            .i_ready  (s_ready[k]),
            .o_item   (s_item[k])
        );
    end

    gcsp_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_valid[PATTERN_BITS]),
        .o_ready       (s_ready[PATTERN_BITS]),
        .i_item        (s_item[PATTERN_BITS]),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_value (o_pixel_value)
    );

endmodule

`default_nettype wire
